[src/dsi_pkg.sv]
// ----------------------------------------------------------------------------
// dsi_pkg
// shared types and constants of the decimal string parser
// ----------------------------------------------------------------------------
package dsi_pkg;

  // width of the result port
  localparam int NUM_W = 64;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // ascii codes
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // result status codes
  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_NAN = 2'd1;
  localparam logic [1:0] ST_OVF = 2'd2;

  // character class
  typedef enum logic [1:0] {
    CLS_MINUS   = 2'd0,
    CLS_ZERO    = 2'd1,
    CLS_NONZERO = 2'd2,
    CLS_OTHER   = 2'd3
  } cls_t;

  // classified beat
  typedef struct packed {
    logic       has_char;
    logic       last;
    cls_t       cls;
    logic [3:0] digit;
  } beat_t;

  // parse phase
  typedef enum logic [3:0] {
    PH_START  = 4'b0001,
    PH_SIGNED = 4'b0010,
    PH_ZERO   = 4'b0100,
    PH_DIGITS = 4'b1000
  } phase_t;

endpackage

[src/dsi_front.sv]
// ----------------------------------------------------------------------------
// dsi_front
// input register: takes one character beat and classifies it
// ----------------------------------------------------------------------------
module dsi_front
  import dsi_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] ch,
  input  logic       char_valid,
  input  logic       last,
  output logic       fr_valid,
  output beat_t      fr_beat,
  input  logic       fr_stall
);

  logic  accept;
  logic  push;
  beat_t beat_next;
  cls_t  cls_next;

  assign in_stall = fr_valid && fr_stall;
  assign accept   = in_valid && !in_stall;
  assign push     = fr_valid && !fr_stall;

  always_comb begin
    if (ch == CH_MINUS) begin
      cls_next = CLS_MINUS;
    end else if (ch == CH_ZERO) begin
      cls_next = CLS_ZERO;
    end else if (ch >= CH_ONE && ch <= CH_NINE) begin
      cls_next = CLS_NONZERO;
    end else begin
      cls_next = CLS_OTHER;
    end
    beat_next.has_char = char_valid;
    beat_next.last     = last;
    beat_next.cls      = cls_next;
    beat_next.digit    = 4'(ch - CH_ZERO);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
    end else if (accept) begin
      fr_valid <= 1'b1;
    end else if (push) begin
      fr_valid <= 1'b0;
    end
    if (accept) begin
      fr_beat <= beat_next;
    end
  end

endmodule

[src/dsi_queue.sv]
// ----------------------------------------------------------------------------
// dsi_queue
// short fifo of classified beats between front and back
// ----------------------------------------------------------------------------
module dsi_queue
  import dsi_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_stall,
  input  beat_t             push_beat,
  output logic              q_valid,
  output beat_t             q_beat,
  input  logic              q_pop,
  output logic [QCNT_W-1:0] q_count
);

  beat_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic              push;
  logic              pop;

  assign push_stall = (q_count == QCNT_W'(QUEUE_DEPTH));
  assign push       = push_valid && !push_stall;
  assign q_valid    = (q_count != '0);
  assign pop        = q_valid && q_pop;
  assign q_beat     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        q_count <= q_count + 1'b1;
      end else if (pop && !push) begin
        q_count <= q_count - 1'b1;
      end
    end
    if (push) begin
      entries[wr_ptr] <= push_beat;
    end
  end

endmodule

[src/dsi_back.sv]
// ----------------------------------------------------------------------------
// dsi_back
// parse state, multiply-accumulate by ten and result register
// ----------------------------------------------------------------------------
module dsi_back
  import dsi_pkg::*;
#(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_valid,
  input  beat_t                   q_beat,
  output logic                    q_pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              status,
  output logic signed [NUM_W-1:0] number
);

  localparam int ACC_W = VALUE_WIDTH + 4;

  phase_t                        phase;
  logic                          is_negative;
  logic signed [VALUE_WIDTH-1:0] accum;
  logic [1:0]                    sticky_error;

  phase_t                        phase_next;
  logic                          is_negative_next;
  logic signed [VALUE_WIDTH-1:0] accum_next;
  logic [1:0]                    sticky_error_next;

  logic signed [ACC_W-1:0]       wide;
  logic signed [ACC_W-1:0]       dig;
  logic signed [ACC_W-1:0]       prod;
  logic signed [ACC_W-1:0]       sum;
  logic [4:0]                    top_bits;
  logic                          ovf;
  logic signed [VALUE_WIDTH-1:0] dig_w;
  logic [1:0]                    status_next;

  assign q_pop = q_valid && (!q_beat.last || !out_valid || !out_stall);

  // next = accum * 10 +/- digit, range check on the guard bits
  always_comb begin
    wide     = ACC_W'(accum);
    dig      = ACC_W'(q_beat.digit);
    dig_w    = VALUE_WIDTH'(q_beat.digit);
    prod     = (wide <<< 3) + (wide <<< 1);
    sum      = is_negative ? prod - dig : prod + dig;
    top_bits = sum[ACC_W-1:VALUE_WIDTH-1];
    ovf      = !((&top_bits) || !(|top_bits));
  end

  always_comb begin
    phase_next        = phase;
    is_negative_next  = is_negative;
    accum_next        = accum;
    sticky_error_next = sticky_error;
    if (q_beat.has_char && sticky_error == ST_OK) begin
      case (phase)
        PH_START, PH_SIGNED: begin
          if (q_beat.cls == CLS_MINUS && phase == PH_START) begin
            is_negative_next = 1'b1;
            phase_next       = PH_SIGNED;
          end else if (q_beat.cls == CLS_ZERO) begin
            phase_next = PH_ZERO;
            accum_next = '0;
          end else if (q_beat.cls == CLS_NONZERO) begin
            phase_next = PH_DIGITS;
            accum_next = is_negative ? -dig_w : dig_w;
          end else begin
            sticky_error_next = ST_NAN;
          end
        end
        PH_DIGITS: begin
          if (q_beat.cls == CLS_ZERO || q_beat.cls == CLS_NONZERO) begin
            if (ovf) begin
              sticky_error_next = ST_OVF;
            end else begin
              accum_next = sum[VALUE_WIDTH-1:0];
            end
          end else begin
            sticky_error_next = ST_NAN;
          end
        end
        default: begin
          sticky_error_next = ST_NAN;
        end
      endcase
    end
    if (sticky_error_next != ST_OK) begin
      status_next = sticky_error_next;
    end else if (phase_next == PH_ZERO || phase_next == PH_DIGITS) begin
      status_next = ST_OK;
    end else begin
      status_next = ST_NAN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_START;
      is_negative  <= 1'b0;
      accum        <= '0;
      sticky_error <= ST_OK;
      out_valid    <= 1'b0;
    end else begin
      if (q_pop) begin
        if (q_beat.last) begin
          phase        <= PH_START;
          is_negative  <= 1'b0;
          accum        <= '0;
          sticky_error <= ST_OK;
        end else begin
          phase        <= phase_next;
          is_negative  <= is_negative_next;
          accum        <= accum_next;
          sticky_error <= sticky_error_next;
        end
      end
      if (q_pop && q_beat.last) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (q_pop && q_beat.last) begin
      status <= status_next;
      number <= (status_next == ST_OK) ? NUM_W'(accum_next) : '0;
    end
  end

endmodule

[src/decimal_string_to_int64_top.sv]
// ----------------------------------------------------------------------------
// decimal_string_to_int64_top
// ascii decimal string to signed integer with overflow detection
// ----------------------------------------------------------------------------
// Takes a decimal string one character per input beat, the final beat marked
// by last, and gives one result beat per string: status (0 success, 1 not a
// number, 2 overflow) and the signed value, sign-extended from VALUE_WIDTH
// bits to 64 (zero unless status is 0). An optional leading minus is taken,
// a leading zero must be the only digit, and an empty string or a lone minus
// is not a number. A beat with char_valid low carries no character and only
// its last flag counts. One character beat is taken every cycle while in_stall
// is low; the last beat of a string goes from the input register through the
// queue to the result register, which drives the output. The per-character
// step is one shift-add multiply by ten plus a digit add and a range check in
// the back end, which sets the clock period. The front end keeps taking beats
// while a result waits on a stalled output, until the two-entry queue fills.
// ----------------------------------------------------------------------------
module decimal_string_to_int64_top
  import dsi_pkg::*;
#(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [7:0]              ch,
  input  logic                    char_valid,
  input  logic                    last,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              status,
  output logic signed [NUM_W-1:0] number
);

  // front to queue
  logic              fr_valid;
  beat_t             fr_beat;
  logic              fr_stall;

  // queue to back
  logic              q_valid;
  beat_t             q_beat;
  logic              q_pop;
  logic [QCNT_W-1:0] q_count;

  // classify and register the incoming beat
  dsi_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .ch         (ch),
    .char_valid (char_valid),
    .last       (last),
    .fr_valid   (fr_valid),
    .fr_beat    (fr_beat),
    .fr_stall   (fr_stall)
  );

  // decouples the front from a stalled result
  dsi_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fr_valid),
    .push_stall (fr_stall),
    .push_beat  (fr_beat),
    .q_valid    (q_valid),
    .q_beat     (q_beat),
    .q_pop      (q_pop),
    .q_count    (q_count)
  );

  // parse state machine and result register
  dsi_back #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_beat    (q_beat),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .number    (number)
  );

`ifndef SYNTH
  // queue never holds more than its depth
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  // a last beat never leaves the queue while a result is held
  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    (q_pop && q_beat.last) |-> !(out_valid && out_stall))
    else $error("result overwritten while stalled");

  // error results carry a zero value
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (number == '0))
    else $error("nonzero value on error result");

  // the front only stalls when it holds a beat
  a_stall_held: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> fr_valid)
    else $error("input stalled with empty front");
`endif

endmodule

[sim/dsi_parse_checker.sv]
// ----------------------------------------------------------------------------
// dsi_parse_checker
// watches both channels of the decimal string parser and checks every result
// ----------------------------------------------------------------------------
// Keeps its own copy of the parse state, updates it on each accepted input
// beat and queues the result that a last beat must give. Each accepted output
// beat is compared field by field with the oldest queued result.
// ----------------------------------------------------------------------------
module dsi_parse_checker
  import dsi_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic [7:0]              ch,
  input  logic                    char_valid,
  input  logic                    last,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic [1:0]              status,
  input  logic signed [NUM_W-1:0] number,
  output int                      fails,
  output int                      waiting,
  output int                      n_ok,
  output int                      n_nan,
  output int                      n_ovf
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [63:0] number;
  } parse_result_t;

  phase_t        ph;
  logic          neg;
  logic [63:0]   acc;
  logic [1:0]    err;
  parse_result_t results_due[$];

  initial begin
    fails   = 0;
    waiting = 0;
    n_ok    = 0;
    n_nan   = 0;
    n_ovf   = 0;
  end

  function automatic void clear_parse();
    ph  = PH_START;
    neg = 1'b0;
    acc = '0;
    err = ST_OK;
  endfunction

  // one character into the running value
  function automatic void digest_char(input logic [7:0] c);
    logic        is_digit;
    logic [63:0] d;
    logic [63:0] mag;
    logic [63:0] lim;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    d = is_digit ? 64'(c - CH_ZERO) : 64'd0;
    if (ph == PH_START && c == CH_MINUS) begin
      neg = 1'b1;
      ph  = PH_SIGNED;
      return;
    end
    if (ph == PH_START || ph == PH_SIGNED) begin
      if (c == CH_ZERO) begin
        ph  = PH_ZERO;
        acc = '0;
      end else if (is_digit) begin
        ph  = PH_DIGITS;
        acc = neg ? -d : d;
      end else begin
        err = ST_NAN;
      end
      return;
    end
    if (ph == PH_ZERO || !is_digit) begin
      err = ST_NAN;
      return;
    end
    mag = neg ? -acc : acc;
    lim = neg ? NEG_LIMIT : POS_LIMIT;
    if (mag > (lim - d) / 64'd10) begin
      err = ST_OVF;
      return;
    end
    mag = mag * 64'd10 + d;
    acc = neg ? -mag : mag;
  endfunction

  function automatic void take_beat(input logic [7:0] c, input logic cv, input logic lst);
    parse_result_t r;
    if (cv && err == ST_OK) digest_char(c);
    if (!lst) return;
    if (err != ST_OK) begin
      r.status = err;
      r.number = '0;
    end else if (ph == PH_ZERO || ph == PH_DIGITS) begin
      r.status = ST_OK;
      r.number = acc;
    end else begin
      r.status = ST_NAN;
      r.number = '0;
    end
    results_due = {results_due, r};
    clear_parse();
  endfunction

  task automatic report_mismatch(input string msg);
    if (fails < 30) $display("[%0t] mismatch: %s", $realtime, msg);
    fails++;
  endtask

  always @(posedge clk) begin : watch
    parse_result_t due;
    if (rst) begin
      clear_parse();
      results_due.delete();
    end else begin
      if (in_valid && !in_stall) take_beat(ch, char_valid, last);
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected, status %0d number %0d",
                                    status, $signed(number)));
        end else begin
          due = results_due.pop_front();
          if (status !== due.status)
            report_mismatch($sformatf("status %0d, expected %0d", status, due.status));
          if (number !== due.number)
            report_mismatch($sformatf("number %0d, expected %0d",
                                      $signed(number), $signed(due.number)));
          case (due.status)
            ST_OK:   n_ok++;
            ST_NAN:  n_nan++;
            default: n_ovf++;
          endcase
        end
      end
    end
    waiting <= results_due.size();
  end

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the decimal string to int64 parser
// ----------------------------------------------------------------------------
// Sends strings one character beat at a time: a short directed set for the
// corner cases, then random strings that are mostly well-formed numbers,
// many of them at the edge of the signed 64-bit range, with broken strings
// and noise mixed in. Both channels idle at random and the output is held
// off for long stretches so the parser fills up. A checker beside the block
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
  import dsi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // stop the random part after about this many beats that carry a character or end a string
  localparam int    BEAT_TARGET = 1700;
  // length of each long output hold-off
  localparam int    HOLD_CYCLES = 300;
  // watchdog, far beyond the slowest correct run
  localparam int    LIMIT_NS    = 20_000_000;
  // first digits of the largest 64-bit magnitude
  localparam string EDGE_DIGITS = "922337203685477580";

  logic                    clk        = 1'b0;
  logic                    rst        = 1'b1;
  logic                    in_valid   = 1'b0;
  logic                    in_stall;
  logic [7:0]              ch         = 8'h00;
  logic                    char_valid = 1'b0;
  logic                    last       = 1'b0;
  logic                    out_valid;
  logic                    out_stall  = 1'b0;
  logic [1:0]              status;
  logic signed [NUM_W-1:0] number;

  int fails;
  int waiting;
  int n_ok;
  int n_nan;
  int n_ovf;

  // text of the string being built, one ascii code per entry
  logic [7:0] text[$];

  int n_beats     = 0;  // beats that carry a character or end a string
  int n_skipped   = 0;  // empty beats that do not end a string
  int n_markers   = 0;  // strings closed by an empty end beat
  int n_strings   = 0;
  int holds_asked = 0;  // written by the sender only
  int holds_done  = 0;  // written by the receiver only
  bit tx_calm     = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  decimal_string_to_int64_top uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .ch         (ch),
    .char_valid (char_valid),
    .last       (last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .number     (number)
  );

  dsi_parse_checker chk (.*);

  // sender idle time before a beat: mostly none, now and then a long one
  function automatic int tx_gap();
    int r;
    if (tx_calm || holds_asked != holds_done) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // receiver stall length, similar in shape to the sender gaps
  function automatic int rx_stall_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 99) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // offer one beat and wait for it to be taken; the caller must be in step with posedge clk
  task automatic send_beat(input logic [7:0] c, input logic cv, input logic lst);
    int gap;
    gap = tx_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    ch         <= c;
    char_valid <= cv;
    last       <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (cv || lst) n_beats++;
  endtask

  // append one character to the text being built
  task automatic put_char(input logic [7:0] c);
    text = {text, c};
  endtask

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) put_char(s[i]);
  endtask

  // optional minus, a nonzero digit, then more digits
  task automatic add_value(input bit minus, input int n_digits);
    if (minus) put_char(CH_MINUS);
    put_char(CH_ONE + 8'($urandom_range(0, 8)));
    for (int i = 1; i < n_digits; i++) put_char(CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  // send the built text; the end is flagged on the last character, or on an
  // empty end beat when asked for (always so for an empty string)
  task automatic play_text(input bit marker);
    for (int i = 0; i < text.size(); i++) begin
      // empty beats inside a string must be ignored by the parser
      if ($urandom_range(0, 11) == 0) begin
        send_beat(8'($urandom), 1'b0, 1'b0);
        n_skipped++;
      end
      send_beat(text[i], 1'b1, !marker && i == text.size() - 1);
    end
    if (marker || text.size() == 0) begin
      send_beat(8'($urandom), 1'b0, 1'b1);
      n_markers++;
    end
    n_strings++;
    text.delete();
  endtask

  // one random string, weighted toward numbers that get deep into the parse
  task automatic random_string();
    int  kind;
    int  sel;
    bit  minus;
    kind  = $urandom_range(0, 99);
    minus = $urandom_range(0, 1);
    if (kind < 35) begin
      // ordinary value, mostly short
      add_value(minus, ($urandom_range(0, 3) == 0) ? $urandom_range(10, 19)
                                                     : $urandom_range(1, 9));
    end else if (kind < 55) begin
      // right around the 64-bit limits
      if (minus) put_char(CH_MINUS);
      sel = $urandom_range(0, 3);
      case (sel)
        0: begin
          add_str(EDGE_DIGITS);
          put_char(CH_ZERO + 8'($urandom_range(0, 9)));
        end
        1: begin
          add_str(EDGE_DIGITS.substr(0, 16));
          put_char(CH_ZERO + 8'($urandom_range(0, 9)));
          put_char(CH_ZERO + 8'($urandom_range(0, 9)));
        end
        2: add_value(1'b0, 20);
        default: begin
          put_char(CH_NINE);
          for (int i = 1; i < 19; i++) put_char(CH_ZERO + 8'($urandom_range(0, 9)));
        end
      endcase
    end else if (kind < 63) begin
      // zero, possibly followed by a forbidden extra digit
      if (minus) put_char(CH_MINUS);
      put_char(CH_ZERO);
      if ($urandom_range(0, 2) == 0) put_char(CH_ZERO + 8'($urandom_range(0, 9)));
    end else if (kind < 83) begin
      // a number with one character swapped for any byte
      add_value(minus, $urandom_range(1, 19));
      if ($urandom_range(0, 3) == 0)
        text[$urandom_range(0, text.size() - 1)] = CH_MINUS;
      else
        text[$urandom_range(0, text.size() - 1)] = 8'($urandom);
    end else if (kind < 95) begin
      // plain noise
      sel = $urandom_range(1, 6);
      for (int i = 0; i < sel; i++) put_char(8'($urandom));
    end else begin
      // empty string or lone minus
      if (minus) put_char(CH_MINUS);
    end
    play_text($urandom_range(0, 4) == 0);
  endtask

  // receiver: random stalls, calm stretches, and long hold-offs on request
  initial begin : rx_side
    int len;
    int calm;
    calm = 0;
    @(posedge clk);
    forever begin
      if (holds_asked != holds_done) begin
        // hold off long enough for the queue to fill and the input to stall
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end else begin
        if (calm > 0) begin
          calm--;
          len = 0;
        end else if ($urandom_range(0, 149) == 0) begin
          calm = $urandom_range(30, 120);
          len  = 0;
        end else begin
          len = rx_stall_len();
        end
        if (len == 0) begin
          out_stall <= 1'b0;
          @(posedge clk);
        end else begin
          out_stall <= 1'b1;
          repeat (len) @(posedge clk);
          out_stall <= 1'b0;
          @(posedge clk);
        end
      end
    end
  end

  // watchdog
  initial begin
    #(LIMIT_NS);
    $display("tb NOT OK");
    $finish;
  end

  initial begin : tx_side
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corner cases
    play_text(1'b1);                  // empty string
    add_str("-");   play_text(1'b0);  // lone minus
    add_str("0");   play_text(1'b0);
    add_str("-0");  play_text(1'b0);
    add_str("07");  play_text(1'b0);  // leading zero with more digits
    add_str("-9");  play_text(1'b0);
    send_beat(8'hA5, 1'b0, 1'b0);     // empty beat between strings
    n_skipped++;
    add_str("4");   play_text(1'b1);  // closed by an empty end beat
    put_char(8'h00); play_text(1'b0);
    put_char(8'hFF); play_text(1'b0);
    add_str("1x2"); play_text(1'b0);  // characters after an error
    add_str("--1"); play_text(1'b0);
    add_str("5-");  play_text(1'b0);

    // random strings
    while (n_beats < BEAT_TARGET) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      if (n_strings == 100 || n_strings == 500) holds_asked++;
      random_string();
    end
    tx_calm = 1'b0;
    in_valid <= 1'b0;

    // drain; the checker's waiting count is registered
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("summary: %0d strings in %0d beats, %0d closed by an end beat, %0d empty beats",
             n_strings, n_beats, n_markers, n_skipped);
    $display("summary: %0d values, %0d not a number, %0d overflow, %0d long output holds",
             n_ok, n_nan, n_ovf, holds_done);
    if (fails == 0 && waiting == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
